[src/bqrc_pkg.sv]
package bqrc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SUB_BITS_DEF   = 8;

  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int SEQ_W     = 32;
  localparam int IO_DATA_W = 32;
  localparam int CNT_OUT_W = 5;
  localparam int EXT_W     = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_SUBSCRIBE   = 3'd0,
    ACT_UNSUBSCRIBE = 3'd1,
    ACT_PUSH        = 3'd2,
    ACT_POP         = 3'd3,
    ACT_HAS         = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_DROPPED   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_WALK,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [SEQ_W-1:0]       next_seq;
    logic [IO_DATA_W-1:0]   pop_data;
    logic                   present;
    logic [CNT_OUT_W-1:0]   entry_count;
    logic                   notify;
  } res_t;

endpackage

[src/bqrc_ram.sv]
module bqrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bqrc_seq.sv]
module bqrc_seq #(
  parameter int DEPTH      = bqrc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bqrc_pkg::DATA_WIDTH_DEF,
  parameter int SUB_BITS   = bqrc_pkg::SUB_BITS_DEF,
  localparam int SW        = $clog2(DEPTH),
  localparam int ENTRY_W   = SUB_BITS + DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bqrc_pkg::ACT_W-1:0]      in_action,
  input  logic [bqrc_pkg::SEQ_W-1:0]      in_seq_number,
  input  logic [bqrc_pkg::IO_DATA_W-1:0]  in_push_data,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  output logic                            mem_we,
  output logic [SW-1:0]                   mem_waddr,
  output logic [ENTRY_W-1:0]              mem_wdata,
  output logic                            mem_re,
  output logic [SW-1:0]                   mem_raddr,
  input  logic [ENTRY_W-1:0]              mem_rdata,
  output logic                            res_valid,
  output bqrc_pkg::res_t                  res,
  input  logic                            res_ready
);

  localparam int PW   = $clog2(DEPTH + 1);
  localparam int SUMW = PW + 1;
  localparam logic [SUB_BITS-1:0] SUB_MAX = {SUB_BITS{1'b1}};

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                            input logic [PW-1:0] off);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(off);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return sum[SW-1:0];
  endfunction

  bqrc_pkg::state_t state_r, state_nxt;

  logic [bqrc_pkg::SEQ_W-1:0]     head_seq_r, head_seq_nxt;
  logic [SW-1:0]                  head_slot_r, head_slot_nxt;
  logic [PW-1:0]                  held_r, held_nxt;
  logic [SUB_BITS-1:0]            sub_r, sub_nxt;
  logic                           notify_en_r;

  logic [PW-1:0]                  pos_r, pos_nxt;
  logic [PW-1:0]                  idx_r, idx_nxt;
  logic [PW-1:0]                  wpos_r, wpos_nxt;
  logic [PW-1:0]                  k_r, k_nxt;
  bqrc_pkg::status_t              stat_r, stat_nxt;
  logic                           present_r, present_nxt;
  logic                           notify_r, notify_nxt;
  logic [bqrc_pkg::IO_DATA_W-1:0] pop_r, pop_nxt;

  logic [bqrc_pkg::SEQ_W-1:0]     pos32;
  logic                           held_in;
  logic [PW-1:0]                  pos_in;
  logic [SUB_BITS-1:0]            rd_cnt;
  logic [bqrc_pkg::EXT_W-1:0]     rd_ext;
  logic [bqrc_pkg::EXT_W-1:0]     push_ext;
  logic                           start_sh;
  logic [PW-1:0]                  sh_k;
  logic [PW-1:0]                  drop_w;

  assign pos32    = in_seq_number - head_seq_r;
  assign held_in  = pos32 < bqrc_pkg::SEQ_W'(held_r);
  assign pos_in   = pos32[PW-1:0];
  assign rd_cnt   = mem_rdata[ENTRY_W-1:DATA_WIDTH];
  assign rd_ext   = bqrc_pkg::EXT_W'(mem_rdata[DATA_WIDTH-1:0]);
  assign push_ext = bqrc_pkg::EXT_W'(in_push_data);
  assign in_stall = (state_r != bqrc_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    head_seq_nxt  = head_seq_r;
    head_slot_nxt = head_slot_r;
    held_nxt      = held_r;
    sub_nxt       = sub_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    wpos_nxt      = wpos_r;
    k_nxt         = k_r;
    stat_nxt      = stat_r;
    present_nxt   = present_r;
    notify_nxt    = notify_r;
    pop_nxt       = pop_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    res_valid     = 1'b0;
    start_sh      = 1'b0;
    sh_k          = '0;
    drop_w        = k_r;

    res.status      = stat_r;
    res.next_seq    = head_seq_r + bqrc_pkg::SEQ_W'(held_r);
    res.pop_data    = pop_r;
    res.present     = present_r;
    res.entry_count = bqrc_pkg::CNT_OUT_W'(held_r);
    res.notify      = notify_r;

    case (state_r)
      bqrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          stat_nxt    = bqrc_pkg::STAT_OK;
          present_nxt = 1'b0;
          notify_nxt  = 1'b0;
          pop_nxt     = '0;
          state_nxt   = bqrc_pkg::ST_FIN;
          case (bqrc_pkg::action_t'(in_action))
            bqrc_pkg::ACT_SUBSCRIBE: begin
              if (sub_r != SUB_MAX) begin
                sub_nxt = sub_r + SUB_BITS'(1);
              end
            end
            bqrc_pkg::ACT_UNSUBSCRIBE: begin
              if (sub_r != '0) begin
                sub_nxt = sub_r - SUB_BITS'(1);
              end
              if (held_in) begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(head_slot_r, pos_in);
                pos_nxt   = pos_in;
                wpos_nxt  = pos_in;
                idx_nxt   = pos_in + PW'(1);
                k_nxt     = '0;
                state_nxt = bqrc_pkg::ST_WALK;
              end
            end
            bqrc_pkg::ACT_PUSH: begin
              if (sub_r == '0) begin
                stat_nxt = bqrc_pkg::STAT_DROPPED;
              end else if (held_r >= PW'(DEPTH)) begin
                stat_nxt = bqrc_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(head_slot_r, held_r);
                mem_wdata  = {sub_r, push_ext[DATA_WIDTH-1:0]};
                held_nxt   = held_r + PW'(1);
                notify_nxt = notify_en_r;
              end
            end
            bqrc_pkg::ACT_POP: begin
              if (!held_in) begin
                stat_nxt = bqrc_pkg::STAT_NOT_FOUND;
              end else begin
                present_nxt = 1'b1;
                mem_re      = 1'b1;
                mem_raddr   = slot_of(head_slot_r, pos_in);
                pos_nxt     = pos_in;
                state_nxt   = bqrc_pkg::ST_POP_RD;
              end
            end
            bqrc_pkg::ACT_HAS: begin
              present_nxt = held_in;
            end
            default: begin
            end
          endcase
        end
      end
      bqrc_pkg::ST_POP_RD: begin
        pop_nxt   = rd_ext[bqrc_pkg::IO_DATA_W-1:0];
        state_nxt = bqrc_pkg::ST_FIN;
        if (rd_cnt == SUB_BITS'(1)) begin
          start_sh = 1'b1;
          sh_k     = PW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_slot_r, pos_r);
          mem_wdata = {rd_cnt - SUB_BITS'(1), mem_rdata[DATA_WIDTH-1:0]};
        end
      end
      bqrc_pkg::ST_WALK: begin
        if (rd_cnt == SUB_BITS'(1)) begin
          drop_w = k_r + PW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_slot_r, wpos_r);
          mem_wdata = {rd_cnt - SUB_BITS'(1), mem_rdata[DATA_WIDTH-1:0]};
        end
        k_nxt = drop_w;
        if (idx_r < held_r) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_slot_r, idx_r);
          wpos_nxt  = idx_r;
          idx_nxt   = idx_r + PW'(1);
        end else begin
          start_sh = 1'b1;
          sh_k     = drop_w;
        end
      end
      bqrc_pkg::ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_slot_r, idx_r + k_r);
        mem_wdata = mem_rdata;
        if (idx_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_slot_r, idx_r - PW'(1));
          idx_nxt   = idx_r - PW'(1);
        end else begin
          head_slot_nxt = slot_of(head_slot_r, k_r);
          head_seq_nxt  = head_seq_r + bqrc_pkg::SEQ_W'(k_r);
          held_nxt      = held_r - k_r;
          state_nxt     = bqrc_pkg::ST_FIN;
        end
      end
      bqrc_pkg::ST_FIN: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = bqrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bqrc_pkg::ST_IDLE;
      end
    endcase

    // close the gap below the removed block
    if (start_sh) begin
      k_nxt = sh_k;
      if (sh_k == '0) begin
        state_nxt = bqrc_pkg::ST_FIN;
      end else if (pos_r == '0) begin
        head_slot_nxt = slot_of(head_slot_r, sh_k);
        head_seq_nxt  = head_seq_r + bqrc_pkg::SEQ_W'(sh_k);
        held_nxt      = held_r - sh_k;
        state_nxt     = bqrc_pkg::ST_FIN;
      end else begin
        mem_re    = 1'b1;
        mem_raddr = slot_of(head_slot_r, pos_r - PW'(1));
        idx_nxt   = pos_r - PW'(1);
        state_nxt = bqrc_pkg::ST_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqrc_pkg::ST_IDLE;
      head_seq_r  <= '0;
      head_slot_r <= '0;
      held_r      <= '0;
      sub_r       <= '0;
      notify_en_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_seq_r  <= head_seq_nxt;
      head_slot_r <= head_slot_nxt;
      held_r      <= held_nxt;
      sub_r       <= sub_nxt;
      if (cfg_wr_en) begin
        notify_en_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    wpos_r    <= wpos_nxt;
    k_r       <= k_nxt;
    stat_r    <= stat_nxt;
    present_r <= present_nxt;
    notify_r  <= notify_nxt;
    pop_r     <= pop_nxt;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= PW'(DEPTH))
    else $error("held count above depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bqrc_pkg::ST_SHIFT) |->
      ((SUMW'(idx_r) + SUMW'(k_r)) < SUMW'(held_r)))
    else $error("shift target outside held range");

  a_sub_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && state_r == bqrc_pkg::ST_IDLE && in_action == bqrc_pkg::ACT_SUBSCRIBE &&
     sub_r == SUB_MAX) |=> (sub_r == SUB_MAX))
    else $error("subscriber count wrapped");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && state_r == bqrc_pkg::ST_IDLE && in_action == bqrc_pkg::ACT_PUSH &&
     sub_r != '0 && held_r < PW'(DEPTH)) |=> (held_r == $past(held_r) + PW'(1)))
    else $error("push did not grow queue");

endmodule

[src/broadcast_queue_reader_counts.sv]
// subscribe, push, has and a missed pop go from idle straight to the finish state
// pop: reads the entry; if kept its count drops, else older entries move up, one ram move each
// unsubscribe: walks the held entries from the position on, plus a shift if entries are freed
// one request at a time through the single-port-pair entry ram; output register decouples
// synchronous active-low reset clears pointers, counts and notify enable; ram is not cleared
module broadcast_queue_reader_counts #(
  parameter int DEPTH      = bqrc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bqrc_pkg::DATA_WIDTH_DEF,
  parameter int SUB_BITS   = bqrc_pkg::SUB_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bqrc_pkg::ACT_W-1:0]      in_action,
  input  logic [bqrc_pkg::SEQ_W-1:0]      in_seq_number,
  input  logic [bqrc_pkg::IO_DATA_W-1:0]  in_push_data,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bqrc_pkg::STAT_W-1:0]     out_status,
  output logic [bqrc_pkg::SEQ_W-1:0]      out_next_seq,
  output logic [bqrc_pkg::IO_DATA_W-1:0]  out_pop_data,
  output logic                            out_present,
  output logic [bqrc_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic                            out_notify
);

  localparam int SW      = $clog2(DEPTH);
  localparam int ENTRY_W = SUB_BITS + DATA_WIDTH;

  logic               mem_we;
  logic [SW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [SW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               res_valid;
  logic               res_ready;
  bqrc_pkg::res_t     res;

  logic               out_valid_r;
  bqrc_pkg::res_t     out_r;

  bqrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bqrc_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .SUB_BITS   (SUB_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_seq_number (in_seq_number),
    .in_push_data  (in_push_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_next_seq    = out_r.next_seq;
  assign out_pop_data    = out_r.pop_data;
  assign out_present     = out_r.present;
  assign out_entry_count = out_r.entry_count;
  assign out_notify      = out_r.notify;

endmodule

[tb/bqrc_reply_checker.sv]
module bqrc_reply_checker
  import bqrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SEQ_W-1:0]     in_seq_number,
  input  logic [IO_DATA_W-1:0] in_push_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STAT_W-1:0]    out_status,
  input  logic [SEQ_W-1:0]     out_next_seq,
  input  logic [IO_DATA_W-1:0] out_pop_data,
  input  logic                 out_present,
  input  logic [CNT_OUT_W-1:0] out_entry_count,
  input  logic                 out_notify,
  output int                   fail_count = 0,
  output int                   replies_pending = 0
);

  localparam int SLOTS  = DEPTH_DEF;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SUB_BITS_DEF-1:0] READERS_MAX = '1;

  logic [IO_DATA_W-1:0]    word_ram [SLOTS];
  logic [SUB_BITS_DEF-1:0] owed_ram [SLOTS];
  logic [SEQ_W-1:0]        oldest_seq;
  logic [SLOT_W-1:0]       oldest_slot;
  logic [CNT_OUT_W-1:0]    held;
  logic [SUB_BITS_DEF-1:0] readers;
  logic                    notify_on;
  res_t                    replies_due[$];
  int                      errors = 0;

  function automatic logic [SLOT_W-1:0] ring_slot(input logic [SEQ_W-1:0] offset);
    return SLOT_W'(oldest_slot + offset);
  endfunction

  function automatic string reply_text(input res_t r);
    return $sformatf("status %0d next_seq %h pop_data %h present %0d entry_count %0d notify %0d",
                     r.status, r.next_seq, r.pop_data, r.present, r.entry_count, r.notify);
  endfunction

  // drop k entries at offset, older entries slide toward the tail
  task automatic close_gap(input logic [SEQ_W-1:0] at, input int unsigned k);
    int unsigned i;
    if (k != 0 && at < held && k <= held - at) begin
      for (i = at; i > 0; i--) begin
        word_ram[ring_slot(i - 1 + k)] = word_ram[ring_slot(i - 1)];
        owed_ram[ring_slot(i - 1 + k)] = owed_ram[ring_slot(i - 1)];
      end
      oldest_slot = oldest_slot + SLOT_W'(k);
      oldest_seq  = oldest_seq + k;
      held        = held - CNT_OUT_W'(k);
    end
  endtask

  task automatic serve_request(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] seq,
                               input logic [IO_DATA_W-1:0] word, output res_t r);
    logic [SEQ_W-1:0]  offset;
    logic              hit;
    logic [SLOT_W-1:0] s;
    int unsigned       i;
    int unsigned       freed;
    offset = seq - oldest_seq;
    hit = offset < held;
    r = '0;
    r.status = STAT_OK;
    case (act)
      ACT_SUBSCRIBE: begin
        if (readers != READERS_MAX) readers = readers + 1'b1;
      end
      ACT_UNSUBSCRIBE: begin
        if (readers != 0) readers = readers - 1'b1;
        if (hit) begin
          freed = 0;
          for (i = offset; i < held; i++) begin
            s = ring_slot(i);
            if (owed_ram[s] == 1) freed++;
            else owed_ram[s] = owed_ram[s] - 1'b1;
          end
          close_gap(offset, freed);
        end
      end
      ACT_PUSH: begin
        if (readers == 0) begin
          r.status = STAT_DROPPED;
        end else if (held >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          s = ring_slot(held);
          word_ram[s] = word;
          owed_ram[s] = readers;
          held = held + 1'b1;
          r.notify = notify_on;
        end
      end
      ACT_POP: begin
        if (!hit) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          s = ring_slot(offset);
          r.present = 1'b1;
          r.pop_data = word_ram[s];
          if (owed_ram[s] == 1) close_gap(offset, 1);
          else owed_ram[s] = owed_ram[s] - 1'b1;
        end
      end
      ACT_HAS: begin
        r.present = hit;
      end
      default: begin
      end
    endcase
    r.next_seq = oldest_seq + held;
    r.entry_count = held;
  endtask

  always @(posedge clk) begin : track
    res_t want;
    res_t got;
    if (!rst_n) begin
      oldest_seq  = '0;
      oldest_slot = '0;
      held        = '0;
      readers     = '0;
      notify_on   = 1'b0;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) notify_on = cfg_wr_data;
      if (in_valid && !in_stall) begin
        serve_request(in_action, in_seq_number, in_push_data, want);
        replies_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.status      = status_t'(out_status);
        got.next_seq    = out_next_seq;
        got.pop_data    = out_pop_data;
        got.present     = out_present;
        got.entry_count = out_entry_count;
        got.notify      = out_notify;
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected reply at %0t: %s", $time, reply_text(got));
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.next_seq !== want.next_seq ||
              got.pop_data !== want.pop_data || got.present !== want.present ||
              got.entry_count !== want.entry_count || got.notify !== want.notify) begin
            errors++;
            if (errors <= 10) begin
              $display("reply mismatch at %0t: expected %s, got %s",
                       $time, reply_text(want), reply_text(got));
            end
          end
        end
      end
    end
    replies_pending <= replies_due.size();
    fail_count <= errors;
  end

endmodule

[tb/tb_broadcast_queue_reader_counts.sv]
module tb_broadcast_queue_reader_counts;
  import bqrc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_CODE_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action = '0;
  logic [SEQ_W-1:0]     in_seq_number = '0;
  logic [IO_DATA_W-1:0] in_push_data = '0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [SEQ_W-1:0]     out_next_seq;
  logic [IO_DATA_W-1:0] out_pop_data;
  logic                 out_present;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic                 out_notify;
  int                   fail_count;
  int                   replies_pending;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic [SEQ_W-1:0]     head_seen = '0;
  logic [CNT_OUT_W-1:0] held_seen = '0;

  always #2 clk = ~clk;

  broadcast_queue_reader_counts dut (.*);

  bqrc_reply_checker checker_i (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (out_valid && !out_stall) begin
      head_seen <= out_next_seq - out_entry_count;
      held_seen <= out_entry_count;
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] seq,
                              input logic [IO_DATA_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_seq_number <= seq;
    in_push_data  <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_replies;
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  task automatic write_notify(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly inside or just past the held range
  function automatic logic [SEQ_W-1:0] pick_seq();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return head_seen + $urandom_range(0, held_seen);
    if (roll < 90) return head_seen - $urandom_range(1, 4);
    return $urandom;
  endfunction

  task automatic random_request(input int push_w, pop_w, sub_w, unsub_w);
    int unsigned roll;
    logic [ACT_W-1:0] act;
    roll = $urandom_range(0, 99);
    if (roll < push_w) act = ACT_PUSH;
    else if (roll < push_w + pop_w) act = ACT_POP;
    else if (roll < push_w + pop_w + sub_w) act = ACT_SUBSCRIBE;
    else if (roll < push_w + pop_w + sub_w + unsub_w) act = ACT_UNSUBSCRIBE;
    else if (roll < 98) act = ACT_HAS;
    else act = ACT_W'($urandom_range(ACT_HAS + 1, ACT_CODE_MAX));
    send_request(act, pick_seq(), $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      drain_replies;
      send_idle_pct  <= (phase == 0) ? 27 : (phase == 1) ? 67 : 0;
      recv_stall_pct <= (phase == 0) ? 67 : (phase == 1) ? 27 : 0;
      write_notify(phase != 1);
      if (phase == 0) begin
        send_request(ACT_HAS, '0, '0);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_PUSH, '0, '1);
        send_request(ACT_UNSUBSCRIBE, '0, '0);
        for (int code = ACT_HAS + 1; code <= ACT_CODE_MAX; code++) begin
          send_request(ACT_W'(code), '1, '1);
        end
        send_request(ACT_SUBSCRIBE, '0, '0);
        send_request(ACT_PUSH, '1, '0);
        send_request(ACT_PUSH, '0, '1);
        send_request(ACT_SUBSCRIBE, '0, '0);
        send_request(ACT_PUSH, '0, 32'ha5a5_5a5a);
        send_request(ACT_HAS, 32'd0, '0);
        send_request(ACT_HAS, 32'd3, '0);
        send_request(ACT_HAS, '1, '0);
        // single reader frees the entry, the older one slides up
        send_request(ACT_POP, 32'd1, '0);
        send_request(ACT_POP, 32'd2, '0);
        send_request(ACT_POP, 32'd2, '0);
        send_request(ACT_POP, '1, '0);
        send_request(ACT_UNSUBSCRIBE, 32'd2, '0);
        send_request(ACT_UNSUBSCRIBE, 32'd100, '0);
        send_request(ACT_SUBSCRIBE, '0, '0);
        send_request(ACT_PUSH, '0, 32'h5a5a_a5a5);
        send_request(ACT_POP, 32'd3, '0);
      end
      for (int chunk = 0; chunk < ((phase == 2) ? 3 : 4); chunk++) begin
        repeat (55) begin
          if (chunk % 2 == 0) random_request(30, 20, 20, 10);
          else random_request(15, 40, 10, 20);
        end
        drain_replies;
      end
    end
    // subscriber count saturation, full queue, then walk everything out
    repeat (260) send_request(ACT_SUBSCRIBE, $urandom, $urandom);
    repeat (20) send_request(ACT_PUSH, $urandom, $urandom);
    repeat (10) send_request(ACT_POP, pick_seq(), '0);
    repeat (260) send_request(ACT_UNSUBSCRIBE, head_seen + $urandom_range(0, 1), '0);
    drain_replies;
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
src/bqrc_pkg.sv
src/bqrc_ram.sv
src/bqrc_seq.sv
src/broadcast_queue_reader_counts.sv
tb/bqrc_reply_checker.sv
tb/tb_broadcast_queue_reader_counts.sv
